/* sv/fnpll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnpll_pkg
// Shared constants, codes and controller/datapath interface types for the
// fractional-N divider setting block.
// ----------------------------------------------------------------------------
package fnpll_pkg;

  // Field widths
  localparam int FREQ_W  = 16;  // input frequency, tenths of MHz
  localparam int MHZ_W   = 13;  // whole MHz after clamp, max 4400
  localparam int K_W     = 3;   // output divider exponent 0..6
  localparam int P_W     = 18;  // scaled divider in thousandths, max 176512
  localparam int INT_W   = 8;   // integer divider, max 176
  localparam int FRAC_W  = 10;  // fraction and modulus, max 1000
  localparam int WORD_W  = 32;
  localparam int WIDX_W  = 2;

  // Frequency range and VCO window
  localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd350;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd44000;
  localparam int                VCO_LOW  = 2200;
  localparam int                VCO_HIGH = 4400;
  localparam int                K_MAX    = 6;
  localparam logic [FRAC_W-1:0] MOD_FULL = 10'd1000;

  // Reciprocal constants for division by constants
  // tenths / 10   : (x * 52429)  >> 19, exact for x < 2^18
  // p / 1000      : (x * 268436) >> 28, exact for x < 2^18
  // x / 5         : (x * 205)    >> 10, exact for x < 2^10
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam int          SH10      = 19;
  localparam logic [18:0] RECIP1000 = 19'd268436;
  localparam int          SH1000    = 28;
  localparam logic [7:0]  RECIP5    = 8'd205;
  localparam int          SH5       = 10;

  // Register word constants
  localparam logic [WORD_W-1:0] WORD_RF_OFF   = 32'h00EC801C;
  localparam logic [WORD_W-1:0] WORD_MOD_BASE = 32'h00008001;
  localparam logic [WORD_W-1:0] WORD_DIV_BASE = 32'h008C803C;

  // Word index codes, in sending order
  localparam logic [WIDX_W-1:0] WIDX_RF_OFF = 2'd0;
  localparam logic [WIDX_W-1:0] WIDX_MOD    = 2'd1;
  localparam logic [WIDX_W-1:0] WIDX_INTFR  = 2'd2;
  localparam logic [WIDX_W-1:0] WIDX_DIV    = 2'd3;

  // Controller states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MHZ  = 8'b0000_0010,
    S_KSEL = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_FRAC = 8'b0001_0000,
    S_RED5 = 8'b0010_0000,
    S_RED2 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;     // capture and clamp input
    logic              mhz_en;   // whole MHz
    logic              ksel_en;  // divider exponent and scaled value
    logic              div_en;   // integer part
    logic              frac_en;  // fraction, modulus reset
    logic              red5_en;  // divide fraction and modulus by 5
    logic              red2_en;  // divide fraction and modulus by 2
    logic [WIDX_W-1:0] widx;     // word to present
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div5_ok;
    logic div2_ok;
  } sts_t;

endpackage

/* sv/fnpll_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnpll_ctrl
// Sequencer: steps the datapath through clamp, divide, exponent search and
// fraction reduction, then hands out the four register words.
// ----------------------------------------------------------------------------
module fnpll_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_tlast,
  output fnpll_pkg::cmd_t      cmd,
  input  fnpll_pkg::sts_t      sts
);

  fnpll_pkg::state_t                   state_r, state_nxt;
  logic [fnpll_pkg::WIDX_W-1:0]        widx_r, widx_nxt;
  logic                                out_xfer;
  logic                                in_xfer;

  assign in_tready  = (state_r == fnpll_pkg::S_IDLE);
  assign out_tvalid = (state_r == fnpll_pkg::S_OUT);
  assign out_tlast  = (widx_r == fnpll_pkg::WIDX_DIV);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    widx_nxt    = widx_r;
    cmd         = '0;
    cmd.widx    = widx_r;
    unique case (state_r)
      fnpll_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          state_nxt = fnpll_pkg::S_MHZ;
        end
      end
      fnpll_pkg::S_MHZ: begin
        cmd.mhz_en = 1'b1;
        state_nxt  = fnpll_pkg::S_KSEL;
      end
      fnpll_pkg::S_KSEL: begin
        cmd.ksel_en = 1'b1;
        state_nxt   = fnpll_pkg::S_DIV;
      end
      fnpll_pkg::S_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = fnpll_pkg::S_FRAC;
      end
      fnpll_pkg::S_FRAC: begin
        cmd.frac_en = 1'b1;
        state_nxt   = fnpll_pkg::S_RED5;
      end
      // one factor of 5 per cycle, at most three
      fnpll_pkg::S_RED5: begin
        if (sts.div5_ok) begin
          cmd.red5_en = 1'b1;
        end else begin
          state_nxt = fnpll_pkg::S_RED2;
        end
      end
      // one factor of 2 per cycle, at most three
      fnpll_pkg::S_RED2: begin
        if (sts.div2_ok) begin
          cmd.red2_en = 1'b1;
        end else begin
          state_nxt = fnpll_pkg::S_OUT;
        end
      end
      fnpll_pkg::S_OUT: begin
        if (out_xfer) begin
          if (widx_r == fnpll_pkg::WIDX_DIV) begin
            widx_nxt  = fnpll_pkg::WIDX_RF_OFF;
            state_nxt = fnpll_pkg::S_IDLE;
          end else begin
            widx_nxt = widx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = fnpll_pkg::S_IDLE;
        widx_nxt  = fnpll_pkg::WIDX_RF_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fnpll_pkg::S_IDLE;
      widx_r  <= fnpll_pkg::WIDX_RF_OFF;
    end else begin
      state_r <= state_nxt;
      widx_r  <= widx_nxt;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == fnpll_pkg::S_MHZ))
    else $error("accepted item did not start the sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (state_r == fnpll_pkg::S_IDLE))
    else $error("block not idle after last word transfer");

  a_widx_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    (widx_r != fnpll_pkg::WIDX_RF_OFF) |-> (state_r == fnpll_pkg::S_OUT))
    else $error("word counter moved outside output phase");

  a_red2_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fnpll_pkg::S_RED2 && !sts.div2_ok) |=> (state_r == fnpll_pkg::S_OUT))
    else $error("reduction did not end in output phase");

endmodule

/* sv/fnpll_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnpll_dp
// Datapath: clamp, constant-reciprocal divides, divider exponent select,
// fraction reduction and register word assembly.
// ----------------------------------------------------------------------------
module fnpll_dp (
  input  logic                              clk,
  input  logic [fnpll_pkg::FREQ_W-1:0]      freq_tenths_mhz,
  input  fnpll_pkg::cmd_t                   cmd,
  output fnpll_pkg::sts_t                   sts,
  output logic [fnpll_pkg::WORD_W-1:0]      reg_word
);

  logic [fnpll_pkg::FREQ_W-1:0] tenths_r;
  logic [fnpll_pkg::MHZ_W-1:0]  mhz_r;
  logic [fnpll_pkg::K_W-1:0]    k_r;
  logic [fnpll_pkg::P_W-1:0]    p_r;
  logic [fnpll_pkg::INT_W-1:0]  int_r;
  logic [fnpll_pkg::FRAC_W-1:0] frac_r;
  logic [fnpll_pkg::FRAC_W-1:0] mod_r;

  logic [fnpll_pkg::FREQ_W-1:0] clamp_nxt;
  logic [31:0]                  mhz_prod;
  logic [fnpll_pkg::K_W-1:0]    k_nxt;
  logic [23:0]                  p_wide;
  logic [36:0]                  int_prod;
  logic [17:0]                  int_x1000;
  logic [17:0]                  frac_diff;
  logic [17:0]                  frac_q5_prod, mod_q5_prod;
  logic [7:0]                   frac_q5, mod_q5;
  logic [fnpll_pkg::FRAC_W-1:0] frac_r5, mod_r5;

  // Input clamp
  always_comb begin
    priority if (freq_tenths_mhz < fnpll_pkg::FREQ_MIN) begin
      clamp_nxt = fnpll_pkg::FREQ_MIN;
    end else if (freq_tenths_mhz > fnpll_pkg::FREQ_MAX) begin
      clamp_nxt = fnpll_pkg::FREQ_MAX;
    end else begin
      clamp_nxt = freq_tenths_mhz;
    end
  end

  // Whole MHz by reciprocal multiply
  assign mhz_prod = tenths_r * fnpll_pkg::RECIP10;

  // Smallest exponent that puts the VCO in its window
  always_comb begin
    logic [18:0] v;
    k_nxt = fnpll_pkg::K_W'(fnpll_pkg::K_MAX);
    for (int j = fnpll_pkg::K_MAX - 1; j >= 0; j--) begin
      v = 19'(mhz_r) << j;
      if (v >= 19'(fnpll_pkg::VCO_LOW) && v <= 19'(fnpll_pkg::VCO_HIGH)) begin
        k_nxt = fnpll_pkg::K_W'(j);
      end
    end
  end

  // Scaled divider in thousandths; bounded below 2^18 for clamped input
  assign p_wide = 24'(tenths_r) << (5'(k_nxt) + 5'd2);

  // Integer part by reciprocal multiply, remainder by back-multiply
  assign int_prod  = p_r * fnpll_pkg::RECIP1000;
  assign int_x1000 = 18'(int_r) * 18'(fnpll_pkg::MOD_FULL);
  assign frac_diff = p_r - int_x1000;

  // Divide-by-5 test on fraction and modulus
  assign frac_q5_prod = frac_r * fnpll_pkg::RECIP5;
  assign mod_q5_prod  = mod_r * fnpll_pkg::RECIP5;
  assign frac_q5      = frac_q5_prod[17:fnpll_pkg::SH5];
  assign mod_q5       = mod_q5_prod[17:fnpll_pkg::SH5];
  assign frac_r5      = frac_r - (10'(frac_q5) * 10'd5);
  assign mod_r5       = mod_r - (10'(mod_q5) * 10'd5);

  assign sts.div5_ok = (frac_r5 == '0) && (mod_r5 == '0);
  assign sts.div2_ok = !frac_r[0] && !mod_r[0];

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tenths_r <= clamp_nxt;
    end
    if (cmd.mhz_en) begin
      mhz_r <= mhz_prod[fnpll_pkg::SH10 + fnpll_pkg::MHZ_W - 1:fnpll_pkg::SH10];
    end
    if (cmd.ksel_en) begin
      k_r <= k_nxt;
      p_r <= p_wide[fnpll_pkg::P_W-1:0];
    end
    if (cmd.div_en) begin
      int_r <= int_prod[fnpll_pkg::SH1000 + fnpll_pkg::INT_W - 1:fnpll_pkg::SH1000];
    end
    if (cmd.frac_en) begin
      frac_r <= frac_diff[fnpll_pkg::FRAC_W-1:0];
      mod_r  <= fnpll_pkg::MOD_FULL;
    end else if (cmd.red5_en) begin
      frac_r <= 10'(frac_q5);
      mod_r  <= 10'(mod_q5);
    end else if (cmd.red2_en) begin
      frac_r <= frac_r >> 1;
      mod_r  <= mod_r >> 1;
    end
  end

  // Output word select
  always_comb begin
    unique case (cmd.widx)
      fnpll_pkg::WIDX_RF_OFF: reg_word = fnpll_pkg::WORD_RF_OFF;
      fnpll_pkg::WIDX_MOD:    reg_word = fnpll_pkg::WORD_MOD_BASE + {19'b0, mod_r, 3'b0};
      fnpll_pkg::WIDX_INTFR:  reg_word = {9'b0, int_r, 15'b0} + {19'b0, frac_r, 3'b0};
      fnpll_pkg::WIDX_DIV:    reg_word = fnpll_pkg::WORD_DIV_BASE + {9'b0, k_r, 20'b0};
      default:                reg_word = fnpll_pkg::WORD_RF_OFF;
    endcase
  end

endmodule

/* sv/frac_n_pll_freq_to_reg_words.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_n_pll_freq_to_reg_words
// Converts a target frequency into the four register words of a
// fractional-N synthesizer with a 25 MHz reference.
// ----------------------------------------------------------------------------
// Each transfer on the input carries a frequency in tenths of MHz, clamped to
// 35.0..4400.0 MHz. The block answers with four 32-bit words in sending order
// (RF off, modulus, int/frac, output divider); tuser carries the word index and
// tlast marks the fourth word. One item is handled at a time: the next item is
// accepted only after the fourth word has gone out. The time per item is set by
// the fraction reduction loop (one factor of 5 or 2 per cycle, up to three of
// each) and by the hand-out of the words, which output stalls can hold.
// ----------------------------------------------------------------------------
module frac_n_pll_freq_to_reg_words (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] freq_tenths_mhz
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] reg_word
  output logic [1:0]  out_tuser,   // [1:0] word_index
  output logic        out_tlast    // last_word
);

  fnpll_pkg::cmd_t cmd;
  fnpll_pkg::sts_t sts;

  fnpll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  fnpll_dp u_dp (
    .clk             (clk),
    .freq_tenths_mhz (in_tdata),
    .cmd             (cmd),
    .sts             (sts),
    .reg_word        (out_tdata)
  );

  assign out_tuser = cmd.widx;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for frac_n_pll_freq_to_reg_words: feeds target frequencies into
// the input stream and checks every register word on the output stream
// against a cycle-free predictor of the divider setting.
// ----------------------------------------------------------------------------
// A directed set covers the clamp limits, the output divider boundaries and
// the fraction reduction cases. Random frequencies follow, mostly in range.
// Both stream sides back off at random in two phases, with the sender and
// receiver rates swapped between them, and a third, last phase has no back-off.
// ----------------------------------------------------------------------------
module tb;

  // Expected register word with its sideband
  typedef struct packed {
    logic [fnpll_pkg::WORD_W-1:0] word;
    logic [fnpll_pkg::WIDX_W-1:0] idx;
    logic                         last;
  } reg_word_t;

  localparam int RANDOM_ITEMS = 405;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  logic [15:0] freq_pending[$];   // frequencies not yet driven
  reg_word_t   words_expected[$]; // register words still owed by the block
  int          total_items = 0;
  int          issued = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  logic        in_taken = 1'b0;    // input transfer at the last rising edge

  frac_n_pll_freq_to_reg_words DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Divider setting predictor: pushes the four words for one frequency
  function automatic void predict_reg_words(input logic [15:0] freq);
    logic [31:0] tenths;
    logic [31:0] mhz;
    logic [31:0] kexp;
    logic [31:0] scaled;
    logic [31:0] int_div;
    logic [31:0] frac;
    logic [31:0] modulus;
    reg_word_t   w;
    tenths = {16'd0, freq};
    if (tenths < 32'(fnpll_pkg::FREQ_MIN)) tenths = 32'(fnpll_pkg::FREQ_MIN);
    if (tenths > 32'(fnpll_pkg::FREQ_MAX)) tenths = 32'(fnpll_pkg::FREQ_MAX);
    mhz = tenths / 10;
    kexp = 32'(fnpll_pkg::K_MAX);
    for (int k = fnpll_pkg::K_MAX - 1; k >= 0; k--) begin
      if ((mhz << k) >= fnpll_pkg::VCO_LOW && (mhz << k) <= fnpll_pkg::VCO_HIGH) begin
        kexp = 32'(k);
      end
    end
    scaled = (tenths << kexp) * 4;
    int_div = scaled / 32'(fnpll_pkg::MOD_FULL);
    frac = scaled % 32'(fnpll_pkg::MOD_FULL);
    modulus = 32'(fnpll_pkg::MOD_FULL);
    while (frac % 5 == 0 && modulus % 5 == 0) begin
      frac = frac / 5;
      modulus = modulus / 5;
    end
    while (frac % 2 == 0 && modulus % 2 == 0) begin
      frac = frac / 2;
      modulus = modulus / 2;
    end
    w = '{word: fnpll_pkg::WORD_RF_OFF, idx: fnpll_pkg::WIDX_RF_OFF, last: 1'b0};
    words_expected.push_back(w);
    w = '{word: fnpll_pkg::WORD_MOD_BASE + (modulus << 3), idx: fnpll_pkg::WIDX_MOD,
          last: 1'b0};
    words_expected.push_back(w);
    w = '{word: (int_div << 15) + (frac << 3), idx: fnpll_pkg::WIDX_INTFR, last: 1'b0};
    words_expected.push_back(w);
    w = '{word: fnpll_pkg::WORD_DIV_BASE + (kexp << 20), idx: fnpll_pkg::WIDX_DIV,
          last: 1'b1};
    words_expected.push_back(w);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Back-off rate in percent for the current phase
  function automatic int backoff_pct(input bit receiver);
    int phase;
    phase = (issued * 3 < total_items) ? 0 : (issued * 3 < 2 * total_items) ? 1 : 2;
    case (phase)
      0: begin
        return receiver ? 55 : 6;
      end
      1: begin
        return receiver ? 6 : 55;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // Input driver: a new transfer is offered once the previous one went through
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (freq_pending.size() != 0 && $urandom_range(99) >= backoff_pct(1'b0)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= freq_pending.pop_front();
        issued++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= backoff_pct(1'b1));
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    reg_word_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_reg_words(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (words_expected.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 32'd0);
        end else begin
          want = words_expected.pop_front();
          if (out_tdata !== want.word) report_mismatch("reg_word", out_tdata, want.word);
          if (out_tuser !== want.idx) report_mismatch("word_index", 32'(out_tuser),
                                                      32'(want.idx));
          if (out_tlast !== want.last) report_mismatch("last_word", 32'(out_tlast),
                                                       32'(want.last));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("[frac_n_pll_freq_to_reg_words] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [15:0] f;
    int          sel;
    // Clamp limits, divider boundaries, zero and reduced fractions
    freq_pending = '{16'd0, 16'd1, 16'd349, 16'd350, 16'd351, 16'd999, 16'd1000,
                     16'd22000, 16'd21999, 16'd22001, 16'd22125, 16'd11000,
                     16'd10999, 16'd5500, 16'd2750, 16'd1375, 16'd687, 16'd4400,
                     16'd44000, 16'd44001, 16'd65535, 16'd65534, 16'd32768,
                     16'd12345, 16'd43999};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = int'($urandom_range(99));
      if (sel < 65) begin
        f = 16'($urandom_range(44000, 350));
      end else if (sel < 75) begin
        // near an output divider boundary
        f = 16'((22000 >> $urandom_range(6)) + $urandom_range(20) - 10);
      end else if (sel < 82) begin
        // whole multiples that leave small or zero fractions
        f = 16'(25 * $urandom_range(1760, 14));
      end else if (sel < 88) begin
        f = 16'($urandom_range(349));
      end else if (sel < 94) begin
        f = 16'($urandom_range(65535, 44001));
      end else begin
        f = 16'($urandom());
      end
      freq_pending.push_back(f);
    end
    total_items = freq_pending.size();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    while (freq_pending.size() != 0 || in_tvalid || words_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    // Words predicted but never delivered
    if (words_expected.size() != 0) begin
      report_mismatch("missing words", 32'(words_expected.size()), 32'd0);
    end

    if (errors == 0) begin
      $display("[frac_n_pll_freq_to_reg_words] OK");
    end else begin
      $display("[frac_n_pll_freq_to_reg_words] ERROR");
    end
    $finish;
  end

endmodule
